>>> sv/two_way_sorted_merge_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-way sorted merge checker
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TWO_WAY_SORTED_MERGE_ASSERT_SVH
`define TWO_WAY_SORTED_MERGE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared constants and types of the two-way sorted merge.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int WAIT_DEPTH = 16;
    localparam int IDX_W      = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W      = $clog2(WAIT_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int DATA_W     = 32;

    localparam logic [1:0] CMD_PUSH_FIRST   = 2'd0;
    localparam logic [1:0] CMD_PUSH_SECOND  = 2'd1;
    localparam logic [1:0] CMD_CLOSE_FIRST  = 2'd2;
    localparam logic [1:0] CMD_CLOSE_SECOND = 2'd3;

    localparam logic [1:0] KIND_ELEM   = 2'd0;
    localparam logic [1:0] KIND_EMPTY  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_PASS     = 5'b00100,
        S_MERGE    = 5'b01000,
        S_CLOSE    = 5'b10000
    } state_t;

endpackage

>>> sv/tsm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_in_if
// Input channel: command word with element value and end-of-list flag.
// ----------------------------------------------------------------------------
interface tsm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] value;
    logic               final_of_list;

    modport source (output valid, output command, output value, output final_of_list,
                    input ready);
    modport sink   (input valid, input command, input value, input final_of_list,
                    output ready);
endinterface

>>> sv/tsm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_out_if
// Output channel: merged element, result kind and end-of-run mark.
// ----------------------------------------------------------------------------
interface tsm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] merged_value;
    logic [1:0]         kind;
    logic               run_end;

    modport source (output valid, output merged_value, output kind, output run_end,
                    input ready);
    modport sink   (input valid, input merged_value, input kind, input run_end,
                    output ready);
endinterface

>>> sv/two_way_sorted_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_sorted_merge
// Merges two ascending signed streams into one, holding waiting elements of
// one list in a circular buffer kept in a one-read one-write synchronous memory.
// ----------------------------------------------------------------------------
// Flow: a word is accepted in S_IDLE and decoded in S_DISPATCH in the next
//   cycle; a reject is emitted from S_DISPATCH into the output register, other
//   results from S_PASS, S_MERGE or S_CLOSE, which pop waiting elements one by
//   one. A new word is taken only back in S_IDLE, after the last one is done;
//   an end-of-list flag adds S_CLOSE and its pops; a stalled result holds all.
// Reset: clears control state and empties the buffer; memory is not cleared.
module two_way_sorted_merge
    import tsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tsm_in_if.sink    in_ch,
    tsm_out_if.source out_ch
);

    logic signed [DATA_W-1:0] mem [WAIT_DEPTH];

    state_t                   state_reg, state_next;
    logic [1:0]               cmd_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic                     fin_reg;
    idx_t                     head_reg, head_next;
    cnt_t                     count_reg, count_next;
    logic                     owner_reg, owner_next;
    logic [1:0]               closed_reg, closed_next;
    logic                     any_reg, any_next;
    logic signed [DATA_W-1:0] rd_data_reg;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] merged_value_reg;
    logic [1:0]               kind_reg;
    logic                     run_end_reg;

    logic                     emit;
    logic signed [DATA_W-1:0] emit_val;
    logic [1:0]               emit_kind;
    logic                     emit_end;
    logic                     pop;
    logic                     app;
    logic                     in_ready;
    logic                     out_free;
    logic                     lst;
    logic                     oth;
    logic                     is_close;
    logic                     beats;
    logic [SUM_W-1:0]         tail_sum;
    idx_t                     wr_addr;

    assign lst      = cmd_reg[0];
    assign oth      = ~cmd_reg[0];
    assign is_close = (cmd_reg == CMD_CLOSE_FIRST) || (cmd_reg == CMD_CLOSE_SECOND);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign beats    = (rd_data_reg < val_reg) || ((rd_data_reg == val_reg) && lst);

    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign wr_addr  = (tail_sum >= SUM_W'(WAIT_DEPTH)) ? IDX_W'(tail_sum - SUM_W'(WAIT_DEPTH))
                                                       : IDX_W'(tail_sum);

    always_comb
    begin
        state_next  = state_reg;
        closed_next = closed_reg;
        emit        = 1'b0;
        emit_val    = '0;
        emit_kind   = KIND_ELEM;
        emit_end    = 1'b0;
        pop         = 1'b0;
        app         = 1'b0;
        in_ready    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_ch.valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (is_close)
                begin
                    state_next = closed_reg[lst] ? S_IDLE : S_CLOSE;
                end
                else if (closed_reg[lst])
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_kind  = KIND_REJECT;
                        state_next = S_IDLE;
                    end
                end
                else if ((count_reg == '0) || (owner_reg == lst))
                begin
                    if (closed_reg[oth])
                    begin
                        state_next = S_PASS;
                    end
                    else if (count_reg == CNT_W'(WAIT_DEPTH))
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            emit_kind  = KIND_REJECT;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        app        = 1'b1;
                        state_next = fin_reg ? S_CLOSE : S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_MERGE;
                end
            end
            S_PASS:
            begin
                if (count_reg != '0)
                begin
                    if (out_free)
                    begin
                        emit     = 1'b1;
                        emit_val = rd_data_reg;
                        pop      = 1'b1;
                    end
                end
                else
                begin
                    app        = 1'b1;
                    state_next = fin_reg ? S_CLOSE : S_IDLE;
                end
            end
            S_MERGE:
            begin
                if ((count_reg != '0) && beats)
                begin
                    if (out_free)
                    begin
                        emit     = 1'b1;
                        emit_val = rd_data_reg;
                        pop      = 1'b1;
                    end
                end
                else if (count_reg == '0)
                begin
                    app        = 1'b1;
                    state_next = fin_reg ? S_CLOSE : S_IDLE;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    emit_val   = val_reg;
                    state_next = fin_reg ? S_CLOSE : S_IDLE;
                end
            end
            S_CLOSE:
            begin
                closed_next[lst] = 1'b1;
                if (closed_reg[oth])
                begin
                    if (count_reg == '0)
                    begin
                        if (any_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (out_free)
                        begin
                            emit       = 1'b1;
                            emit_kind  = KIND_EMPTY;
                            emit_end   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else if (out_free)
                    begin
                        emit     = 1'b1;
                        emit_val = rd_data_reg;
                        emit_end = (count_reg == CNT_W'(1));
                        pop      = 1'b1;
                    end
                end
                else if ((count_reg > CNT_W'(1)) && (owner_reg == oth))
                begin
                    if (out_free)
                    begin
                        emit     = 1'b1;
                        emit_val = rd_data_reg;
                        pop      = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        owner_next     = owner_reg;
        any_next       = any_reg;
        out_valid_next = out_valid_reg;

        if (pop)
        begin
            head_next  = (head_reg == IDX_W'(WAIT_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (app)
        begin
            count_next = count_reg + 1'b1;
            owner_next = lst;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (emit_kind == KIND_ELEM)
            begin
                any_next = 1'b1;
            end
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (app)
        begin
            mem[wr_addr] <= val_reg;
        end
    end

    // forward an append that lands on the next head
    always_ff @(posedge clk)
    begin
        if (app && (wr_addr == head_next))
        begin
            rd_data_reg <= val_reg;
        end
        else
        begin
            rd_data_reg <= mem[head_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            owner_reg     <= 1'b0;
            closed_reg    <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            owner_reg     <= owner_next;
            closed_reg    <= closed_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_ch.valid)
        begin
            cmd_reg <= in_ch.command;
            val_reg <= in_ch.value;
            fin_reg <= in_ch.final_of_list;
        end
        if (emit)
        begin
            merged_value_reg <= emit_val;
            kind_reg         <= emit_kind;
            run_end_reg      <= emit_end;
        end
    end

    assign in_ch.ready         = in_ready;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.merged_value = merged_value_reg;
    assign out_ch.kind         = kind_reg;
    assign out_ch.run_end      = run_end_reg;

endmodule

>>> sv/tsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_checker
// Port-level checks on the result channel of the two-way sorted merge.
// ----------------------------------------------------------------------------
`include "two_way_sorted_merge_assert.svh"

module tsm_checker
    import tsm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] merged_value,
    input logic [1:0]         kind,
    input logic               run_end
);

    `TSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(merged_value) && $stable(kind) && $stable(run_end), "stalled result word changed")
    `TSM_ASSERT_SAME(a_kind_code, out_valid, (kind == KIND_ELEM) || (kind == KIND_EMPTY) || (kind == KIND_REJECT), "unknown result kind")
    `TSM_ASSERT_SAME(a_reject_clean, out_valid && (kind == KIND_REJECT), !run_end && (merged_value == 32'sd0), "reject word carries data or end mark")
    `TSM_ASSERT_SAME(a_empty_marker, out_valid && (kind == KIND_EMPTY), run_end && (merged_value == 32'sd0), "empty marker without end mark or with data")

endmodule

bind two_way_sorted_merge tsm_checker u_tsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .merged_value (out_ch.merged_value),
    .kind         (out_ch.kind),
    .run_end      (out_ch.run_end)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Runs one long merge of two ascending lists through two_way_sorted_merge.
// The run starts with ties between the lists, a full buffer and a rejected
// push. Random runs of sorted words follow, with a little noise. It ends with
// the closing sequence and with words sent after the merge has finished. A
// model of the merge predicts every output word, and each word is checked in
// order while both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import tsm_pkg::*;

    localparam longint VALUE_MIN = -64'sd2147483648;
    localparam longint VALUE_MAX = 64'sd2147483647;

    typedef struct {
        logic [1:0]         command;
        logic signed [31:0] value;
        logic               final_of_list;
        bit                 drain_first;
    } list_word_t;

    typedef struct {
        logic signed [31:0] merged_value;
        logic [1:0]         kind;
        logic               run_end;
    } merge_out_t;

    logic clk;
    logic rst_n;

    tsm_in_if  in_ch ();
    tsm_out_if out_ch ();

    two_way_sorted_merge dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    list_word_t send_words[$];
    merge_out_t merged_due[$];

    logic signed [31:0] held_values [WAIT_DEPTH];
    int held_head   = 0;
    int held_count  = 0;
    bit held_owner  = 1'b0;
    bit first_done  = 1'b0;
    bit second_done = 1'b0;
    bit emitted_any = 1'b0;

    longint cursor [2];

    int words_taken   = 0;
    int words_checked = 0;
    int elems_seen    = 0;
    int rejects_seen  = 0;
    int end_marks     = 0;
    int mismatches    = 0;

    bit         in_taken     = 1'b0;
    int         gap_left     = 0;
    int         burst_left   = 0;
    int         ready_window = 0;
    logic [7:0] ready_pattern = 8'hff;

    function automatic bit list_done(bit l);
        return l ? second_done : first_done;
    endfunction

    function automatic void due_word(logic signed [31:0] v, logic [1:0] k, logic e);
        merge_out_t r;
        r.merged_value = v;
        r.kind         = k;
        r.run_end      = e;
        merged_due.insert(merged_due.size(), r);
        if (k == KIND_ELEM)
            emitted_any = 1'b1;
    endfunction

    function automatic logic signed [31:0] take_oldest();
        logic signed [31:0] v;
        v = held_values[held_head];
        held_head = (held_head + 1 >= WAIT_DEPTH) ? 0 : held_head + 1;
        held_count--;
        return v;
    endfunction

    function automatic void hold_value(logic signed [31:0] v, bit owner);
        int slot;
        slot = held_head + held_count;
        if (slot >= WAIT_DEPTH)
            slot -= WAIT_DEPTH;
        held_values[slot] = v;
        held_count++;
        held_owner = owner;
    endfunction

    function automatic void close_list(bit l);
        logic signed [31:0] v;
        if (l)
            second_done = 1'b1;
        else
            first_done = 1'b1;
        if (list_done(!l))
        begin
            if (held_count == 0)
            begin
                if (!emitted_any)
                    due_word('0, KIND_EMPTY, 1'b1);
            end
            else
            begin
                while (held_count > 0)
                begin
                    v = take_oldest();
                    due_word(v, KIND_ELEM, held_count == 0);
                end
            end
        end
        else if (held_count > 0 && held_owner == !l)
        begin
            while (held_count > 1)
            begin
                v = take_oldest();
                due_word(v, KIND_ELEM, 1'b0);
            end
        end
    endfunction

    function automatic void merge_step(logic [1:0] cmd, logic signed [31:0] v, logic fin);
        bit                 l;
        bit                 m;
        logic signed [31:0] hv;
        l = cmd[0];
        m = !l;
        if (cmd == CMD_CLOSE_FIRST || cmd == CMD_CLOSE_SECOND)
        begin
            if (!list_done(l))
                close_list(l);
            return;
        end
        if (list_done(l))
        begin
            due_word('0, KIND_REJECT, 1'b0);
            return;
        end
        if (held_count == 0 || held_owner == l)
        begin
            if (list_done(m))
            begin
                while (held_count > 0)
                begin
                    hv = take_oldest();
                    due_word(hv, KIND_ELEM, 1'b0);
                end
                hold_value(v, l);
            end
            else if (held_count >= WAIT_DEPTH)
            begin
                due_word('0, KIND_REJECT, 1'b0);
                return;
            end
            else
                hold_value(v, l);
        end
        else
        begin
            while (held_count > 0 && (held_values[held_head] < v ||
                   (held_values[held_head] == v && m == 1'b0)))
            begin
                hv = take_oldest();
                due_word(hv, KIND_ELEM, 1'b0);
            end
            if (held_count == 0)
                hold_value(v, l);
            else
                due_word(v, KIND_ELEM, 1'b0);
        end
        if (fin)
            close_list(l);
    endfunction

    function automatic logic [1:0] push_code(bit l);
        return l ? CMD_PUSH_SECOND : CMD_PUSH_FIRST;
    endfunction

    function automatic logic [1:0] close_code(bit l);
        return l ? CMD_CLOSE_SECOND : CMD_CLOSE_FIRST;
    endfunction

    function automatic longint clamp_top(longint v);
        return (v > VALUE_MAX) ? VALUE_MAX : v;
    endfunction

    function automatic void add_word(logic [1:0] c, longint v, logic f, bit drain);
        list_word_t w;
        w.command       = c;
        w.value         = v[31:0];
        w.final_of_list = f;
        w.drain_first   = drain;
        send_words.insert(send_words.size(), w);
    endfunction

    function automatic longint next_in_list(bit l);
        int                 pick;
        logic signed [31:0] noise;
        pick = $urandom_range(0, 39);
        if (pick < 2)
        begin
            noise = $urandom;
            return longint'(noise);
        end
        if (pick < 6 && cursor[!l] > cursor[l])
            cursor[l] = cursor[!l];
        else if (pick >= 9)
            cursor[l] = clamp_top(cursor[l] + $urandom_range(0, 40_000_000));
        return cursor[l];
    endfunction

    function automatic void log_mismatch(string what, merge_out_t want, merge_out_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected value %0d kind %0d end %0d, got value %0d kind %0d end %0d",
                     $time, what, want.merged_value, want.kind, want.run_end,
                     got.merged_value, got.kind, got.run_end);
    endfunction

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(negedge clk)
    begin : drive_words
        list_word_t w;
        logic       next_valid;
        if (rst_n && !(in_ch.valid && !in_taken))
        begin
            next_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (send_words.size() > 0 &&
                     !(send_words[0].drain_first && merged_due.size() > 0))
            begin
                w = send_words.pop_front();
                in_ch.command       <= w.command;
                in_ch.value         <= w.value;
                in_ch.final_of_list <= w.final_of_list;
                next_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(0, 8);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
            in_ch.valid <= next_valid;
        end
    end

    always @(negedge clk)
    begin : drive_ready
        if (ready_window == 0)
        begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = 8'hff;
                1:       ready_pattern = 8'($urandom) | 8'h10;
                2:       ready_pattern = 8'h81;
                default: ready_pattern = 8'hee;
            endcase
            ready_window = $urandom_range(16, 64);
        end
        else
            ready_window--;
        out_ch.ready <= ready_pattern[ready_window % 8];
    end

    always @(posedge clk)
    begin : watch_words
        merge_out_t got;
        merge_out_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                merge_step(in_ch.command, in_ch.value, in_ch.final_of_list);
                words_taken++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got.merged_value = out_ch.merged_value;
                got.kind         = out_ch.kind;
                got.run_end      = out_ch.run_end;
                words_checked++;
                if (got.kind == KIND_ELEM)
                    elems_seen++;
                if (got.kind == KIND_REJECT)
                    rejects_seen++;
                if (got.run_end)
                    end_marks++;
                if (merged_due.size() == 0)
                    log_mismatch("unexpected word", got, got);
                else
                begin
                    want = merged_due.pop_front();
                    if (got.merged_value !== want.merged_value || got.kind !== want.kind ||
                        got.run_end !== want.run_end)
                        log_mismatch("mismatch", want, got);
                end
            end
        end
    end

    initial
    begin : run_main
        bit     side;
        bit     a;
        bit     b;
        int     run_len;
        longint top;

        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.command       = CMD_PUSH_FIRST;
        in_ch.value         = '0;
        in_ch.final_of_list = 1'b0;
        out_ch.ready        = 1'b0;

        add_word(CMD_PUSH_FIRST, VALUE_MIN, 1'b0, 1'b0);
        add_word(CMD_PUSH_SECOND, VALUE_MIN, 1'b0, 1'b0);
        add_word(CMD_PUSH_FIRST, VALUE_MIN, 1'b0, 1'b0);
        for (int i = 0; i < 16; i++)
            add_word(CMD_PUSH_SECOND, VALUE_MIN + 648 + 10 * i, 1'b0, 1'b0);
        add_word(CMD_PUSH_FIRST, VALUE_MIN + 748, 1'b0, 1'b0);
        cursor[0] = VALUE_MIN + 748;
        cursor[1] = VALUE_MIN + 808;

        while (send_words.size() < 232)
        begin
            side    = $urandom_range(0, 1);
            run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20)
                                                  : $urandom_range(1, 4);
            for (int i = 0; i < run_len; i++)
                add_word(push_code(side), next_in_list(side), 1'b0,
                         send_words.size() == 20 || send_words.size() == 120);
        end

        a   = $urandom_range(0, 1);
        b   = !a;
        top = (cursor[0] > cursor[1]) ? cursor[0] : cursor[1];
        for (int i = 0; i < 3; i++)
        begin
            cursor[b] = clamp_top(top + 1000 * (i + 1));
            add_word(push_code(b), cursor[b], 1'b0, i == 0);
        end
        add_word(push_code(a), cursor[a], 1'b1, 1'b0);
        add_word(push_code(a), longint'($urandom), 1'b1, 1'b1);
        add_word(close_code(a), longint'($urandom), 1'b0, 1'b0);
        for (int i = 0; i < 6; i++)
        begin
            cursor[b] = clamp_top(cursor[b] + $urandom_range(0, 20_000_000));
            add_word(push_code(b), cursor[b], 1'b0, 1'b0);
        end
        add_word(push_code(a), VALUE_MIN, 1'b0, 1'b0);
        add_word(push_code(b), VALUE_MAX, 1'b0, 1'b0);
        add_word(close_code(b), 64'sd0, 1'b1, 1'b1);
        add_word(CMD_PUSH_FIRST, 64'sd0, 1'b1, 1'b1);
        add_word(CMD_PUSH_SECOND, -64'sd1, 1'b0, 1'b0);
        add_word(CMD_CLOSE_FIRST, 64'sd0, 1'b0, 1'b0);
        add_word(CMD_CLOSE_SECOND, 64'sd0, 1'b0, 1'b0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (send_words.size() > 0 || in_ch.valid === 1'b1 || merged_due.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("merge run: %0d words taken, %0d results checked (%0d elements, %0d rejects, %0d end marks)",
                 words_taken, words_checked, elems_seen, rejects_seen, end_marks);
        $display("covered list ties, full buffer, pass-through after a close, words after run end");
        if (mismatches == 0 && merged_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
